@@ src/assert_macros.svh @@
// Assertion macros used by the checker file drq_checker.
// Each macro wraps one clocked concurrent assertion with a reset guard.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while the active-low reset is asserted
`define ASSERT_CLK(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("assertion failed");

// Same check under the default clock and reset names of this project
`define ASSERT_ACLK(lbl, prop) \
    `ASSERT_CLK(lbl, aclk, aresetn, prop)

`endif

@@ src/drq_pkg.sv @@
// Package for the dedup retry queue: codes, field widths and shared types.
// Used by drq_cell, dedup_retry_queue and drq_checker.
package drq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int KEY_BITS_DEF    = 32;
    localparam int MAX_OUT         = 16;
    localparam int STAMP_W         = 48;
    localparam int TIME_W          = 32;
    localparam int TRIES_W         = 8;
    localparam int INTV_W          = 16;
    localparam int CNT32_W         = 32;

    // input function codes
    localparam logic [1:0] FUNC_ENQ     = 2'd0;
    localparam logic [1:0] FUNC_PASS    = 2'd1;
    localparam logic [1:0] FUNC_OUTCOME = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_ENQ  = 2'd0;
    localparam logic [1:0] KIND_REQ  = 2'd1;
    localparam logic [1:0] KIND_OUT  = 2'd2;
    localparam logic [1:0] KIND_NONE = 2'd3;

    // result status codes
    localparam logic [2:0] ST_NEW      = 3'd0;
    localparam logic [2:0] ST_UPDATED  = 3'd1;
    localparam logic [2:0] ST_SKIPPED  = 3'd2;
    localparam logic [2:0] ST_NEW_DROP = 3'd3;
    localparam logic [2:0] ST_REMOVED  = 3'd4;
    localparam logic [2:0] ST_GIVEN_UP = 3'd5;
    localparam logic [2:0] ST_KEPT     = 3'd6;
    localparam logic [2:0] ST_IGNORED  = 3'd7;

    // register map
    localparam int         PADDR_W      = 3;
    localparam logic [2:0] ADDR_INTV    = 3'd0;
    localparam logic [2:0] ADDR_MAX_ATT = 3'd4;
    localparam logic [INTV_W-1:0]  INTV_RST    = 16'd5;
    localparam logic [TRIES_W-1:0] MAX_ATT_RST = 8'd10;
    localparam logic [TRIES_W-1:0] TRIES_MAX   = 8'hFF;

    // per-entry payload held by a cell (key and slot travel separately)
    typedef struct packed {
        logic [STAMP_W-1:0] stamp;
        logic               action;
        logic [TRIES_W-1:0] tries;
        logic [TIME_W-1:0]  last_try;
    } entry_t;

    // per-cell command from the controller
    typedef struct packed {
        logic load;
        logic shift;
        logic update;
        logic bump;
    } cell_ctrl_t;

endpackage

@@ src/drq_cell.sv @@
// One queue position: holds an entry and takes its younger neighbor's entry on shift.
// Depends on drq_pkg.
module drq_cell import drq_pkg::*; #(
    parameter int KEY_BITS = KEY_BITS_DEF,
    parameter int SLOT_W   = 4
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  cell_ctrl_t          ctrl,
    input  logic                nb_valid,
    input  logic [SLOT_W-1:0]   nb_slot,
    input  logic [KEY_BITS-1:0] nb_key,
    input  entry_t              nb_ent,
    input  logic [SLOT_W-1:0]   new_slot,
    input  logic [KEY_BITS-1:0] new_key,
    input  entry_t              new_ent,
    input  logic [INTV_W-1:0]   interval,
    output logic                valid,
    output logic [SLOT_W-1:0]   slot,
    output logic [KEY_BITS-1:0] key,
    output entry_t              ent,
    output logic                due
);

    logic                valid_reg;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    entry_t              ent_reg, ent_next;
    logic [TIME_W-1:0]   elapsed;

    // next entry: load beats shift beats in-place edits
    always_comb begin
        slot_next = slot_reg;
        key_next  = key_reg;
        ent_next  = ent_reg;
        if (ctrl.load) begin
            slot_next = new_slot;
            key_next  = new_key;
            ent_next  = new_ent;
        end else if (ctrl.shift) begin
            slot_next = nb_slot;
            key_next  = nb_key;
            ent_next  = nb_ent;
        end else if (ctrl.update) begin
            ent_next.stamp    = new_ent.stamp;
            ent_next.action   = new_ent.action;
            ent_next.last_try = new_ent.last_try;
        end else if (ctrl.bump) begin
            if (ent_reg.tries != TRIES_MAX) begin
                ent_next.tries = ent_reg.tries + 1'b1;
            end
            ent_next.last_try = new_ent.last_try;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ctrl.load) begin
            valid_reg <= 1'b1;
        end else if (ctrl.shift) begin
            valid_reg <= nb_valid;
        end
    end

    always_ff @(posedge aclk) begin
        slot_reg <= slot_next;
        key_reg  <= key_next;
        ent_reg  <= ent_next;
    end

    // due test against the broadcast current time; clock going back is not due
    assign elapsed = new_ent.last_try - ent_reg.last_try;
    assign due = valid_reg && (new_ent.last_try >= ent_reg.last_try)
                 && (elapsed >= {{(TIME_W-INTV_W){1'b0}}, interval});

    assign valid = valid_reg;
    assign slot  = slot_reg;
    assign key   = key_reg;
    assign ent   = ent_reg;

endmodule

@@ src/dedup_retry_queue.sv @@
// Top level of the dedup retry queue: register port, controller, row of cells.
// Depends on drq_pkg and drq_cell.
//
// Usage: items enter on the s_ valid/ready channel, results leave on the m_
// channel; every result of an item carries m_last on its final transfer.
// Registers retry_interval_sec (byte address 0) and max_attempts (address 4)
// are written over the APB-style port; the user must do so only while the
// block is idle, which the block itself leaves unenforced.
// Cell 0 holds the oldest entry; removal shifts younger cells down one place.
// An enqueue, an outcome or an unknown function gives a single result, decided
// in the exec state and registered in the output register. A retry pass gives
// one result per due entry, up to 16, or one nothing-due result, walking the
// cells through one output register at one result per cycle while not stalled.
// s_ready is high only between items; the next item is taken while the last
// result still waits in the output register.
// Reset empties the queue and clears the counters at once; no clearing pass.
// A receiver stall holds the output register and pauses the pass walk.
module dedup_retry_queue import drq_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int KEY_BITS    = KEY_BITS_DEF,
    localparam int SLOT_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
    localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic                aclk,
    input  logic                aresetn,
    // input channel
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_func,
    input  logic [KEY_BITS-1:0] s_key,
    input  logic [STAMP_W-1:0]  s_stamp,
    input  logic                s_action,
    input  logic [TIME_W-1:0]   s_now_sec,
    input  logic [SLOT_W-1:0]   s_slot,
    input  logic                s_success,
    // result channel
    output logic                m_valid,
    input  logic                m_ready,
    output logic [1:0]          m_kind,
    output logic [2:0]          m_status,
    output logic [SLOT_W-1:0]   m_entry_slot,
    output logic [KEY_BITS-1:0] m_entry_key,
    output logic                m_entry_action,
    output logic [TRIES_W-1:0]  m_attempt_number,
    output logic [KEY_BITS-1:0] m_dropped_key,
    output logic [CNT_W-1:0]    m_queue_count,
    output logic [CNT32_W-1:0]  m_drop_total,
    output logic [CNT32_W-1:0]  m_retry_total,
    output logic                m_last,
    // configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam int POS_W = SLOT_W;
    localparam int NCNT_W = $clog2(MAX_OUT);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_PASS = 2'd2;

    // configuration registers
    logic [INTV_W-1:0]  intv_reg;
    logic [TRIES_W-1:0] max_att_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            intv_reg    <= INTV_RST;
            max_att_reg <= MAX_ATT_RST;
        end else if (psel && penable && pwrite) begin
            if (paddr == ADDR_INTV) begin
                intv_reg <= pwdata[INTV_W-1:0];
            end else if (paddr == ADDR_MAX_ATT) begin
                max_att_reg <= pwdata[TRIES_W-1:0];
            end
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr == ADDR_INTV) begin
            prdata = {{(32-INTV_W){1'b0}}, intv_reg};
        end else if (paddr == ADDR_MAX_ATT) begin
            prdata = {{(32-TRIES_W){1'b0}}, max_att_reg};
        end
    end
    assign pready = 1'b1;

    // controller state and captured item
    logic [1:0]          state_reg, state_next;
    logic [1:0]          func_reg;
    logic [KEY_BITS-1:0] key_in_reg;
    logic [STAMP_W-1:0]  stamp_in_reg;
    logic                action_in_reg;
    logic [TIME_W-1:0]   now_in_reg;
    logic [SLOT_W-1:0]   slot_in_reg;
    logic                success_in_reg;
    logic [POS_W-1:0]    ptr_reg, ptr_next;
    logic [NCNT_W-1:0]   n_reg, n_next;
    logic [CNT_W-1:0]    occ_reg, occ_next;
    logic [CNT32_W-1:0]  drop_reg, drop_next;
    logic [CNT32_W-1:0]  att_reg, att_next;
    logic [QUEUE_DEPTH-1:0] used_reg, used_next;

    // cell row
    cell_ctrl_t          ctrl [QUEUE_DEPTH];
    logic                cell_valid [QUEUE_DEPTH];
    logic [SLOT_W-1:0]   cell_slot [QUEUE_DEPTH];
    logic [KEY_BITS-1:0] cell_key [QUEUE_DEPTH];
    entry_t              cell_ent [QUEUE_DEPTH];
    logic                cell_due [QUEUE_DEPTH];
    logic [SLOT_W-1:0]   free_slot;
    entry_t              new_ent;

    assign new_ent = '{stamp: stamp_in_reg, action: action_in_reg,
                       tries: '0, last_try: now_in_reg};

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        logic                nb_valid;
        logic [SLOT_W-1:0]   nb_slot;
        logic [KEY_BITS-1:0] nb_key;
        entry_t              nb_ent;
        if (g == QUEUE_DEPTH - 1) begin : g_end
            assign nb_valid = 1'b0;
            assign nb_slot  = '0;
            assign nb_key   = '0;
            assign nb_ent   = '0;
        end else begin : g_mid
            assign nb_valid = cell_valid[g+1];
            assign nb_slot  = cell_slot[g+1];
            assign nb_key   = cell_key[g+1];
            assign nb_ent   = cell_ent[g+1];
        end
        drq_cell #(.KEY_BITS(KEY_BITS), .SLOT_W(SLOT_W)) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctrl     (ctrl[g]),
            .nb_valid (nb_valid),
            .nb_slot  (nb_slot),
            .nb_key   (nb_key),
            .nb_ent   (nb_ent),
            .new_slot (free_slot),
            .new_key  (key_in_reg),
            .new_ent  (new_ent),
            .interval (intv_reg),
            .valid    (cell_valid[g]),
            .slot     (cell_slot[g]),
            .key      (cell_key[g]),
            .ent      (cell_ent[g]),
            .due      (cell_due[g])
        );
    end

    // search results across the row
    logic             key_found, slot_found, due_found, due_later;
    logic [POS_W-1:0] key_pos, slot_pos, due_pos;
    logic             full;
    logic [QUEUE_DEPTH-1:0] free_vec;

    assign full = (occ_reg == CNT_W'(QUEUE_DEPTH));

    always_comb begin
        key_found  = 1'b0;
        slot_found = 1'b0;
        due_found  = 1'b0;
        due_later  = 1'b0;
        key_pos    = '0;
        slot_pos   = '0;
        due_pos    = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (cell_valid[i] && cell_key[i] == key_in_reg && !key_found) begin
                key_found = 1'b1;
                key_pos   = POS_W'(i);
            end
            if (cell_valid[i] && cell_slot[i] == slot_in_reg && !slot_found) begin
                slot_found = 1'b1;
                slot_pos   = POS_W'(i);
            end
        end
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (cell_due[i] && POS_W'(i) >= ptr_reg) begin
                if (due_found) begin
                    due_later = 1'b1;
                end else begin
                    due_found = 1'b1;
                    due_pos   = POS_W'(i);
                end
            end
        end
    end

    // lowest free slot, counting the oldest slot as free when it is dropped
    always_comb begin
        free_vec  = ~used_reg;
        free_slot = '0;
        if (full) begin
            free_vec[cell_slot[0]] = 1'b1;
        end
        for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
            if (free_vec[i]) begin
                free_slot = SLOT_W'(i);
            end
        end
    end

    // output register
    logic                m_valid_reg;
    logic [1:0]          kind_reg, kind_next;
    logic [2:0]          status_reg, status_next;
    logic [SLOT_W-1:0]   eslot_reg, eslot_next;
    logic [KEY_BITS-1:0] ekey_reg, ekey_next;
    logic                eact_reg, eact_next;
    logic [TRIES_W-1:0]  etries_reg, etries_next;
    logic [KEY_BITS-1:0] dkey_reg, dkey_next;
    logic                last_reg, last_next;
    logic                emit, out_free;
    logic [TRIES_W-1:0]  bumped;

    assign out_free = !m_valid_reg || m_ready;
    assign bumped = (cell_ent[due_pos].tries == TRIES_MAX) ? TRIES_MAX
                    : cell_ent[due_pos].tries + 1'b1;

    // controller
    always_comb begin
        state_next  = state_reg;
        ptr_next    = ptr_reg;
        n_next      = n_reg;
        occ_next    = occ_reg;
        drop_next   = drop_reg;
        att_next    = att_reg;
        used_next   = used_reg;
        emit        = 1'b0;
        kind_next   = KIND_ENQ;
        status_next = ST_IGNORED;
        eslot_next  = '0;
        ekey_next   = '0;
        eact_next   = 1'b0;
        etries_next = '0;
        dkey_next   = '0;
        last_next   = 1'b1;
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            ctrl[i] = '0;
        end
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = (s_func == FUNC_PASS) ? S_PASS : S_EXEC;
                    ptr_next   = '0;
                    n_next     = '0;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    emit       = 1'b1;
                    state_next = S_IDLE;
                    if (func_reg == FUNC_ENQ) begin
                        kind_next = KIND_ENQ;
                        if (key_found) begin
                            eslot_next  = cell_slot[key_pos];
                            ekey_next   = cell_key[key_pos];
                            etries_next = cell_ent[key_pos].tries;
                            if (stamp_in_reg > cell_ent[key_pos].stamp) begin
                                ctrl[key_pos].update = 1'b1;
                                status_next = ST_UPDATED;
                                eact_next   = action_in_reg;
                            end else begin
                                status_next = ST_SKIPPED;
                                eact_next   = cell_ent[key_pos].action;
                            end
                        end else begin
                            status_next = ST_NEW;
                            if (full) begin
                                for (int i = 0; i < QUEUE_DEPTH; i++) begin
                                    ctrl[i].shift = 1'b1;
                                end
                                ctrl[QUEUE_DEPTH-1].load = 1'b1;
                                used_next[cell_slot[0]]  = 1'b0;
                                dkey_next   = cell_key[0];
                                drop_next   = drop_reg + 1'b1;
                                status_next = ST_NEW_DROP;
                            end else begin
                                ctrl[occ_reg[POS_W-1:0]].load = 1'b1;
                                occ_next = occ_reg + 1'b1;
                            end
                            used_next[free_slot] = 1'b1;
                            eslot_next = free_slot;
                            ekey_next  = key_in_reg;
                            eact_next  = action_in_reg;
                        end
                    end else if (func_reg == FUNC_OUTCOME) begin
                        kind_next  = KIND_OUT;
                        eslot_next = slot_in_reg;
                        if (slot_found && cell_ent[slot_pos].tries != '0) begin
                            ekey_next   = cell_key[slot_pos];
                            eact_next   = cell_ent[slot_pos].action;
                            etries_next = cell_ent[slot_pos].tries;
                            if (success_in_reg ||
                                cell_ent[slot_pos].tries >= max_att_reg) begin
                                for (int i = 0; i < QUEUE_DEPTH; i++) begin
                                    ctrl[i].shift = (POS_W'(i) >= slot_pos);
                                end
                                used_next[slot_in_reg] = 1'b0;
                                occ_next = occ_reg - 1'b1;
                                if (success_in_reg) begin
                                    status_next = ST_REMOVED;
                                end else begin
                                    status_next = ST_GIVEN_UP;
                                    drop_next   = drop_reg + 1'b1;
                                end
                            end else begin
                                status_next = ST_KEPT;
                            end
                        end
                    end
                end
            end
            S_PASS: begin
                if (out_free) begin
                    emit = 1'b1;
                    if (due_found) begin
                        ctrl[due_pos].bump = 1'b1;
                        att_next    = att_reg + 1'b1;
                        kind_next   = KIND_REQ;
                        status_next = ST_NEW;
                        eslot_next  = cell_slot[due_pos];
                        ekey_next   = cell_key[due_pos];
                        eact_next   = cell_ent[due_pos].action;
                        etries_next = bumped;
                        last_next   = !due_later || (n_reg == NCNT_W'(MAX_OUT - 1));
                        ptr_next    = due_pos + 1'b1;
                        n_next      = n_reg + 1'b1;
                    end else begin
                        kind_next   = KIND_NONE;
                        status_next = ST_NEW;
                    end
                    if (last_next) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            ptr_reg     <= '0;
            n_reg       <= '0;
            occ_reg     <= '0;
            drop_reg    <= '0;
            att_reg     <= '0;
            used_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            ptr_reg   <= ptr_next;
            n_reg     <= n_next;
            occ_reg   <= occ_next;
            drop_reg  <= drop_next;
            att_reg   <= att_next;
            used_reg  <= used_next;
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // captured item and result payload
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            func_reg       <= s_func;
            key_in_reg     <= s_key;
            stamp_in_reg   <= s_stamp;
            action_in_reg  <= s_action;
            now_in_reg     <= s_now_sec;
            slot_in_reg    <= s_slot;
            success_in_reg <= s_success;
        end
        if (emit) begin
            kind_reg   <= kind_next;
            status_reg <= status_next;
            eslot_reg  <= eslot_next;
            ekey_reg   <= ekey_next;
            eact_reg   <= eact_next;
            etries_reg <= etries_next;
            dkey_reg   <= dkey_next;
            last_reg   <= last_next;
            m_queue_count <= occ_next;
            m_drop_total  <= drop_next;
            m_retry_total <= att_next;
        end
    end

    assign s_ready          = (state_reg == S_IDLE);
    assign m_valid          = m_valid_reg;
    assign m_kind           = kind_reg;
    assign m_status         = status_reg;
    assign m_entry_slot     = eslot_reg;
    assign m_entry_key      = ekey_reg;
    assign m_entry_action   = eact_reg;
    assign m_attempt_number = etries_reg;
    assign m_dropped_key    = dkey_reg;
    assign m_last           = last_reg;

endmodule

@@ src/drq_checker.sv @@
// Port-level checker for dedup_retry_queue, attached by bind.
// Depends on drq_pkg and assert_macros.svh.
`include "assert_macros.svh"

module drq_checker import drq_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int KEY_BITS    = KEY_BITS_DEF,
    localparam int SLOT_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
    localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1)
) (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic [1:0]          s_func,
    input logic [KEY_BITS-1:0] s_key,
    input logic [STAMP_W-1:0]  s_stamp,
    input logic                s_action,
    input logic [TIME_W-1:0]   s_now_sec,
    input logic [SLOT_W-1:0]   s_slot,
    input logic                s_success,
    input logic                m_valid,
    input logic                m_ready,
    input logic [1:0]          m_kind,
    input logic [2:0]          m_status,
    input logic [SLOT_W-1:0]   m_entry_slot,
    input logic [KEY_BITS-1:0] m_entry_key,
    input logic                m_entry_action,
    input logic [TRIES_W-1:0]  m_attempt_number,
    input logic [KEY_BITS-1:0] m_dropped_key,
    input logic [CNT_W-1:0]    m_queue_count,
    input logic [CNT32_W-1:0]  m_drop_total,
    input logic [CNT32_W-1:0]  m_retry_total,
    input logic                m_last,
    input logic                psel,
    input logic                penable,
    input logic                pwrite,
    input logic [PADDR_W-1:0]  paddr,
    input logic [31:0]         pwdata,
    input logic [31:0]         prdata,
    input logic                pready
);

    // one item at a time: an accepted transfer makes the block busy
    `ASSERT_ACLK(a_busy_after_accept, (s_valid && s_ready) |=> !s_ready)
    // a pass keeps streaming: a non-final transfer is followed by the next result
    `ASSERT_ACLK(a_pass_streams, (m_valid && m_ready && !m_last) |=> m_valid)
    // nothing-due result always closes its item
    `ASSERT_ACLK(a_none_is_last, (m_valid && m_kind == KIND_NONE) |-> m_last)
    // occupancy never exceeds the depth
    `ASSERT_ACLK(a_count_bound, m_valid |-> (m_queue_count <= CNT_W'(QUEUE_DEPTH)))

endmodule

bind dedup_retry_queue drq_checker #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .KEY_BITS(KEY_BITS)
) u_drq_checker (.*);

@@ tb/sv/dedup_retry_queue_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for dedup_retry_queue: directed and random items,
// checked against an in-bench model of the queue. Depends on drq_pkg and the RTL.
module dedup_retry_queue_tb;
    import drq_pkg::*;

    // one result transfer
    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  status;
        logic [3:0]  slot;
        logic [31:0] key;
        logic        action;
        logic [7:0]  tries;
        logic [31:0] dropped;
        logic [4:0]  count;
        logic [31:0] drops;
        logic [31:0] retries;
        logic        last;
    } reply_t;

    localparam int DEPTH = 16;
    localparam longint CYCLE_LIMIT = 400000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [1:0] s_func = '0;
    logic [31:0] s_key = '0;
    logic [47:0] s_stamp = '0;
    logic s_action = 1'b0;
    logic [31:0] s_now_sec = '0;
    logic [3:0] s_slot = '0;
    logic s_success = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [1:0] m_kind;
    logic [2:0] m_status;
    logic [3:0] m_entry_slot;
    logic [31:0] m_entry_key;
    logic m_entry_action;
    logic [7:0] m_attempt_number;
    logic [31:0] m_dropped_key;
    logic [4:0] m_queue_count;
    logic [31:0] m_drop_total;
    logic [31:0] m_retry_total;
    logic m_last;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    dedup_retry_queue u_dut (.*);

    always #5 aclk = ~aclk;

    // queue model
    logic [31:0] q_key [DEPTH];
    logic [47:0] q_stamp [DEPTH];
    logic q_action [DEPTH];
    logic [7:0] q_tries [DEPTH];
    logic [31:0] q_last_try [DEPTH];
    logic q_used [DEPTH];
    logic [3:0] q_age [DEPTH];
    int unsigned q_count;
    logic [31:0] drop_cnt, attempt_cnt;
    logic [15:0] interval_reg;
    logic [7:0] max_att_reg;

    reply_t expected_replies[$];
    int unsigned error_count = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    longint cycle_count = 0;
    logic [31:0] clock_sec = 32'd100;
    logic [31:0] used_keys[$];

    task automatic report_mismatch(input string what);
        $display("ERROR @%0t: %s", $realtime, what);
        error_count++;
    endtask

    function automatic reply_t make_reply(input logic [1:0] kind, input logic [2:0] st,
            input logic [3:0] sl, input logic [31:0] k, input logic a,
            input logic [7:0] t, input logic [31:0] d);
        reply_t r;
        r.kind = kind; r.status = st; r.slot = sl; r.key = k; r.action = a;
        r.tries = t; r.dropped = d; r.count = q_count[4:0]; r.drops = drop_cnt;
        r.retries = attempt_cnt; r.last = 1'b0;
        return r;
    endfunction

    task automatic drop_position(input int unsigned pos);
        q_used[q_age[pos]] = 1'b0;
        for (int unsigned i = pos; i + 1 < q_count; i++) q_age[i] = q_age[i + 1];
        q_count--;
    endtask

    // compute replies for one item and queue them
    task automatic predict_queue(input logic [1:0] f, input logic [31:0] k,
            input logic [47:0] st, input logic a, input logic [31:0] now,
            input logic [3:0] sl, input logic ok);
        reply_t r[$];
        int unsigned s, p;
        logic [31:0] dk;
        logic [2:0] code;
        bit found;
        found = 0;
        case (f)
            FUNC_ENQ: begin
                for (p = 0; p < q_count && !found; p++) begin
                    s = q_age[p];
                    if (q_key[s] == k) begin
                        found = 1;
                        if (st > q_stamp[s]) begin
                            q_stamp[s] = st; q_action[s] = a; q_last_try[s] = now;
                            code = ST_UPDATED;
                        end else begin
                            code = ST_SKIPPED;
                        end
                        r.push_back(make_reply(KIND_ENQ, code, 4'(s), q_key[s], q_action[s],
                            q_tries[s], 0));
                    end
                end
                if (!found) begin
                    dk = 0; code = ST_NEW;
                    if (q_count >= DEPTH) begin
                        dk = q_key[q_age[0]];
                        drop_position(0);
                        drop_cnt++;
                        code = ST_NEW_DROP;
                    end
                    for (s = 0; s < DEPTH; s++) if (!q_used[s]) break;
                    q_used[s] = 1; q_key[s] = k; q_stamp[s] = st; q_action[s] = a;
                    q_tries[s] = 0; q_last_try[s] = now;
                    q_age[q_count] = 4'(s); q_count++;
                    r.push_back(make_reply(KIND_ENQ, code, 4'(s), k, a, 0, dk));
                end
            end
            FUNC_PASS: begin
                for (p = 0; p < q_count && r.size() < MAX_OUT; p++) begin
                    s = q_age[p];
                    if (now < q_last_try[s] || now - q_last_try[s] < interval_reg) continue;
                    if (q_tries[s] != TRIES_MAX) q_tries[s]++;
                    q_last_try[s] = now;
                    attempt_cnt++;
                    r.push_back(make_reply(KIND_REQ, ST_NEW, 4'(s), q_key[s], q_action[s],
                        q_tries[s], 0));
                end
                if (r.size() == 0) r.push_back(make_reply(KIND_NONE, ST_NEW, 0, 0, 0, 0, 0));
            end
            FUNC_OUTCOME: begin
                s = sl;
                if (!q_used[s] || q_tries[s] == 0) begin
                    r.push_back(make_reply(KIND_OUT, ST_IGNORED, 4'(s), 0, 0, 0, 0));
                end else begin
                    for (p = 0; p < q_count; p++) if (q_age[p] == s) break;
                    if (ok) begin
                        code = ST_REMOVED;
                        drop_position(p);
                    end else if (q_tries[s] >= max_att_reg) begin
                        code = ST_GIVEN_UP;
                        drop_position(p);
                        drop_cnt++;
                    end else begin
                        code = ST_KEPT;
                    end
                    r.push_back(make_reply(KIND_OUT, code, 4'(s), q_key[s], q_action[s],
                        q_tries[s], 0));
                end
            end
            default: r.push_back(make_reply(KIND_ENQ, ST_IGNORED, 0, 0, 0, 0, 0));
        endcase
        r[r.size() - 1].last = 1'b1;
        foreach (r[i]) expected_replies.push_back(r[i]);
    endtask

    // send one item, with random idle cycles before it; valid stays up until
    // the next item or an idle cycle replaces it
    task automatic send_item(input logic [1:0] f, input logic [31:0] k,
            input logic [47:0] st, input logic a, input logic [31:0] now,
            input logic [3:0] sl, input logic ok);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1; s_func <= f; s_key <= k; s_stamp <= st; s_action <= a;
        s_now_sec <= now; s_slot <= sl; s_success <= ok;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_queue(f, k, st, a, now, sl, ok);
    endtask

    // register write, only while idle
    task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        @(posedge aclk);
        if (addr == ADDR_INTV) interval_reg = data[15:0];
        else max_att_reg = data[7:0];
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (expected_replies.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic configure(input logic [15:0] intv, input logic [7:0] maxa);
        wait_idle();
        write_reg(ADDR_INTV, {16'd0, intv});
        write_reg(ADDR_MAX_ATT, {24'd0, maxa});
    endtask

    function automatic logic [3:0] pick_slot();
        int unsigned tried[$];
        for (int i = 0; i < DEPTH; i++) if (q_used[i] && q_tries[i] != 0) tried.push_back(i);
        if (tried.size() != 0 && $urandom_range(9) < 8)
            return 4'(tried[$urandom_range(tried.size() - 1)]);
        return 4'($urandom_range(15));
    endfunction

    function automatic logic [31:0] pick_key();
        if (used_keys.size() != 0 && $urandom_range(2) != 0)
            return used_keys[$urandom_range(used_keys.size() - 1)];
        return $urandom();
    endfunction

    // result checking
    always @(posedge aclk) begin
        reply_t got, want;
        if (aresetn && m_valid && m_ready) begin
            got = {m_kind, m_status, m_entry_slot, m_entry_key, m_entry_action,
                m_attempt_number, m_dropped_key, m_queue_count, m_drop_total,
                m_retry_total, m_last};
            if (expected_replies.size() == 0) begin
                report_mismatch("result with no expected transfer");
            end else begin
                want = expected_replies.pop_front();
                if (got.kind != want.kind) report_mismatch($sformatf("kind %0d want %0d", got.kind, want.kind));
                if (got.status != want.status) report_mismatch($sformatf("status %0d want %0d", got.status, want.status));
                if (got.slot != want.slot) report_mismatch($sformatf("slot %0d want %0d", got.slot, want.slot));
                if (got.key != want.key) report_mismatch($sformatf("key %h want %h", got.key, want.key));
                if (got.action != want.action) report_mismatch("entry_action mismatch");
                if (got.tries != want.tries) report_mismatch($sformatf("attempts %0d want %0d", got.tries, want.tries));
                if (got.dropped != want.dropped) report_mismatch($sformatf("dropped %h want %h", got.dropped, want.dropped));
                if (got.count != want.count) report_mismatch($sformatf("count %0d want %0d", got.count, want.count));
                if (got.drops != want.drops) report_mismatch($sformatf("drops %0d want %0d", got.drops, want.drops));
                if (got.retries != want.retries) report_mismatch($sformatf("retries %0d want %0d", got.retries, want.retries));
                if (got.last != want.last) report_mismatch("last mismatch");
            end
        end
    end

    // receiver stalls
    always @(posedge aclk) m_ready <= ($urandom_range(99) >= recv_stall_pct);

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic test_directed();
        logic [31:0] t;
        t = clock_sec;
        send_item(FUNC_PASS, 0, 0, 0, t, 0, 0);                    // empty pass
        send_item(FUNC_OUTCOME, 0, 0, 0, t, 4'd15, 1);             // free slot
        send_item(2'd3, 32'hFFFF_FFFF, 0, 1, t, 0, 0);             // unknown func
        send_item(FUNC_ENQ, 32'h0, 48'h0, 0, t, 0, 0);
        send_item(FUNC_ENQ, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1, t, 0, 0);
        send_item(FUNC_ENQ, 32'h0, 48'h0, 1, t, 0, 0);             // equal stamp: skip
        send_item(FUNC_ENQ, 32'h0, 48'h5, 1, t, 0, 0);             // newer: update
        send_item(FUNC_OUTCOME, 0, 0, 0, t, 4'd0, 0);              // never tried
        send_item(FUNC_PASS, 0, 0, 0, t + 2, 0, 0);                // not due yet
        send_item(FUNC_PASS, 0, 0, 0, t + 5, 0, 0);                // both due
        send_item(FUNC_PASS, 0, 0, 0, t - 3, 0, 0);                // clock went back
        send_item(FUNC_OUTCOME, 0, 0, 0, t, 4'd0, 0);              // kept
        send_item(FUNC_OUTCOME, 0, 0, 0, t, 4'd1, 1);              // removed ok
        // fill past capacity so the oldest is dropped
        for (int i = 0; i < 17; i++)
            send_item(FUNC_ENQ, 32'(32'h1000 + i), 48'(i), i[0], t + 5, 0, 0);
        clock_sec = t + 100;
        send_item(FUNC_PASS, 0, 0, 0, clock_sec, 0, 0);            // long pass, 16 requests
    endtask

    task automatic test_limits();
        configure(16'd0, 8'd0);                                    // all due, give up at once
        send_item(FUNC_PASS, 0, 0, 0, clock_sec, 0, 0);
        send_item(FUNC_OUTCOME, 0, 0, 0, clock_sec, pick_slot(), 0);
        configure(16'hFFFF, 8'hFF);
        send_item(FUNC_PASS, 0, 0, 0, clock_sec + 10, 0, 0);
        send_item(FUNC_OUTCOME, 0, 0, 0, clock_sec, pick_slot(), 0);
        configure(16'd0, 8'd2);
        // saturate the try count of whatever is queued
        for (int i = 0; i < 255; i++) send_item(FUNC_PASS, 0, 0, 0, clock_sec, 0, 0);
        send_item(FUNC_OUTCOME, 0, 0, 0, clock_sec, pick_slot(), 0);
    endtask

    task automatic test_random(input int n);
        int sel;
        logic [31:0] k;
        for (int i = 0; i < n; i++) begin
            sel = $urandom_range(99);
            clock_sec = clock_sec + $urandom_range(4);
            if (sel < 40) begin
                k = pick_key();
                if (used_keys.size() < 24) used_keys.push_back(k);
                send_item(FUNC_ENQ, k, 48'({$urandom(), $urandom()}),
                    1'($urandom_range(1)),
                    ($urandom_range(19) == 0) ? $urandom() : clock_sec, 0, 0);
            end else if (sel < 65) begin
                send_item(FUNC_PASS, $urandom(), 0, 1'($urandom_range(1)),
                    ($urandom_range(19) == 0) ? $urandom() : clock_sec, 0, 0);
            end else if (sel < 97) begin
                send_item(FUNC_OUTCOME, 0, 0, 0, clock_sec, pick_slot(),
                    1'($urandom_range(1)));
            end else begin
                send_item(2'd3, $urandom(), 0, 0, $urandom(), 4'($urandom_range(15)), 1);
            end
        end
    endtask

    initial begin
        for (int i = 0; i < DEPTH; i++) q_used[i] = 0;
        q_count = 0; drop_cnt = 0; attempt_cnt = 0;
        interval_reg = INTV_RST; max_att_reg = MAX_ATT_RST;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_limits();
        configure(16'd3, 8'd4);
        test_random(12);
        send_idle_pct = 65;
        configure(16'd1, 8'd1);
        test_random(12);
        send_idle_pct = 0; recv_stall_pct = 65;
        configure(16'd5, 8'd10);
        test_random(12);
        send_idle_pct = 37; recv_stall_pct = 37;
        configure(16'd2, 8'd3);
        test_random(12);
        wait_idle();
        if (error_count == 0) $display("Testbench completed without errors");
        else $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
